// ----- rtl/aes_counter_keystream_generator_top_assert.svh -----
// Assertion macros for the counter-mode keystream generator.
`ifndef AES_COUNTER_KEYSTREAM_GENERATOR_TOP_ASSERT_SVH
`define AES_COUNTER_KEYSTREAM_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define AKG_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define AKG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AKG_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define AKG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/akg_pkg.sv -----
// Shared types, constants and AES helper functions.
`timescale 1ns / 1ps
`default_nettype none
package akg_pkg;

   localparam int KEY_WORDS_MAX = 8;
   localparam logic [7:0] RCON_INIT = 8'h01;
   localparam logic [7:0] GF_POLY   = 8'h1b;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_KEYRD,
      ST_ROUND,
      ST_FINISH
   } akg_state_type;

   localparam logic [2:0] CSR_KEY0  = 3'd0;
   localparam logic [2:0] CSR_KEY1  = 3'd1;
   localparam logic [2:0] CSR_KEY2  = 3'd2;
   localparam logic [2:0] CSR_KEY3  = 3'd3;
   localparam logic [2:0] CSR_KLEN  = 3'd4;
   localparam logic [2:0] CSR_NONCE = 3'd5;
   localparam logic [2:0] CSR_MASKH = 3'd6;
   localparam logic [2:0] CSR_MASKL = 3'd7;

   localparam logic [1:0] KLEN_128 = 2'd0;
   localparam logic [1:0] KLEN_192 = 2'd1;

   typedef struct packed {
      logic       ld_ctr;
      logic       kx_en;
      logic       kx_first;
      logic [5:0] kx_idx;
      logic [3:0] rd_addr;
      logic       ark_en;
      logic       rnd_en;
      logic       rnd_last;
      logic       out_en;
   } akg_cmd_type;

   typedef struct packed {
      logic [3:0] nr;
      logic [3:0] nk;
   } akg_status_type;

   localparam logic [2047:0] SBOX_TABLE = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
   };

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_TABLE[2047 - 8 * int'(x) -: 8];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
   endfunction

endpackage
`default_nettype wire

// ----- rtl/akg_ctrl.sv -----
// Sequencer for key expansion, rounds and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module akg_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_fire,
   input  wire                    req_mode,
   input  wire                    rsp_tready,
   input  akg_pkg::akg_status_type status,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   output akg_pkg::akg_cmd_type   cmd
);
   import akg_pkg::*;

   akg_state_type state_ff, state_in;
   logic [5:0]    idx_ff, idx_in;
   logic [3:0]    rnd_ff, rnd_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [5:0]    last_word;

   assign last_word  = {status.nr + 4'd1, 2'b00} - 6'd1;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.kx_idx   = idx_ff;
      cmd.rd_addr  = rnd_ff + 4'd1;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               if (req_mode) begin
                  cmd.ld_ctr = 1'b1;
               end else begin
                  idx_in   = '0;
                  state_in = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            cmd.kx_en    = 1'b1;
            cmd.kx_first = (idx_ff == 6'd0);
            if (idx_ff == last_word) begin
               state_in = ST_KEYRD;
            end else begin
               idx_in = idx_ff + 6'd1;
            end
         end
         ST_KEYRD: begin
            // fetch round key 0 ahead of the first round
            cmd.rd_addr = '0;
            rnd_in      = '0;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.ark_en   = (rnd_ff == 4'd0);
            cmd.rnd_en   = (rnd_ff != 4'd0);
            cmd.rnd_last = (rnd_ff == status.nr);
            rnd_in       = rnd_ff + 4'd1;
            if (rnd_ff == status.nr) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output slot frees up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_en   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/akg_dpath.sv -----
// Registers, key expansion, round-key banks, AES round and counter.
`timescale 1ns / 1ps
`default_nettype none
module akg_dpath (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_fire,
   input  wire  [2:0]              csr_index,
   input  wire  [63:0]             csr_data,
   input  wire  [63:0]             load_value,
   input  akg_pkg::akg_cmd_type    cmd,
   output akg_pkg::akg_status_type status,
   output logic [127:0]            rsp_data
);
   import akg_pkg::*;

   logic [63:0]  key_ff [4];
   logic [1:0]   klen_ff;
   logic [63:0]  nonce_ff, mask_hi_ff, mask_lo_ff, ctr_ff;
   logic [31:0]  win_ff [KEY_WORDS_MAX];
   logic [2:0]   pos_ff;
   logic [7:0]   rcon_ff;
   logic [31:0]  bank0 [15];
   logic [31:0]  bank1 [15];
   logic [31:0]  bank2 [15];
   logic [31:0]  bank3 [15];
   logic [31:0]  rk_ff [4];
   logic [127:0] st_ff, st_in;
   logic [127:0] rsp_ff;

   logic [3:0]   nk;
   logic [2:0]   pos_cur;
   logic [7:0]   rcon_cur;
   logic [31:0]  key_wd, tmp, new_wd, back_wd;
   logic         use_key, rc_step;
   logic [127:0] sb, sr, mc, rk;

   always_comb begin
      case (klen_ff)
         KLEN_128: nk = 4'd4;
         KLEN_192: nk = 4'd6;
         default:  nk = 4'd8;
      endcase
   end
   assign status.nk = nk;
   assign status.nr = nk + 4'd6;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         klen_ff    <= '0;
         nonce_ff   <= '0;
         mask_hi_ff <= '0;
         mask_lo_ff <= '0;
         ctr_ff     <= '0;
      end else begin
         if (csr_fire) begin
            case (csr_index)
               CSR_KEY0:  key_ff[0]  <= csr_data;
               CSR_KEY1:  key_ff[1]  <= csr_data;
               CSR_KEY2:  key_ff[2]  <= csr_data;
               CSR_KEY3:  key_ff[3]  <= csr_data;
               CSR_KLEN:  klen_ff    <= csr_data[1:0];
               CSR_NONCE: nonce_ff   <= csr_data;
               CSR_MASKH: mask_hi_ff <= csr_data;
               CSR_MASKL: mask_lo_ff <= csr_data;
               default:   ;
            endcase
         end
         if (cmd.ld_ctr) begin
            ctr_ff <= load_value;
         end else if (cmd.out_en) begin
            ctr_ff <= ctr_ff + 64'd1;
         end
      end
   end

   // key schedule: one word a beat through a window of the last eight words
   assign pos_cur  = cmd.kx_first ? 3'd0 : pos_ff;
   assign rcon_cur = cmd.kx_first ? RCON_INIT : rcon_ff;
   assign use_key  = ({2'b00, nk} > cmd.kx_idx);
   assign key_wd   = cmd.kx_idx[0] ? key_ff[cmd.kx_idx[2:1]][31:0]
                                   : key_ff[cmd.kx_idx[2:1]][63:32];
   assign back_wd  = win_ff[3'(nk - 4'd1)];
   assign rc_step  = !use_key && (pos_cur == 3'd0);

   always_comb begin
      tmp = win_ff[0];
      if (pos_cur == 3'd0) begin
         tmp = sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rcon_cur, 24'd0};
      end else if (nk == 4'd8 && pos_cur == 3'd4) begin
         tmp = sub_word(win_ff[0]);
      end
      new_wd = use_key ? key_wd : (back_wd ^ tmp);
   end

   always_ff @(posedge clock) begin
      if (cmd.kx_en) begin
         win_ff[0] <= new_wd;
         for (int i = 1; i < KEY_WORDS_MAX; i++) win_ff[i] <= win_ff[i-1];
         pos_ff  <= (pos_cur == 3'(nk - 4'd1)) ? 3'd0 : pos_cur + 3'd1;
         rcon_ff <= rc_step ? xtime(rcon_cur) : rcon_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.kx_en) begin
         case (cmd.kx_idx[1:0])
            2'd0:    bank0[cmd.kx_idx[5:2]] <= new_wd;
            2'd1:    bank1[cmd.kx_idx[5:2]] <= new_wd;
            2'd2:    bank2[cmd.kx_idx[5:2]] <= new_wd;
            default: bank3[cmd.kx_idx[5:2]] <= new_wd;
         endcase
      end
      rk_ff[0] <= bank0[cmd.rd_addr];
      rk_ff[1] <= bank1[cmd.rd_addr];
      rk_ff[2] <= bank2[cmd.rd_addr];
      rk_ff[3] <= bank3[cmd.rd_addr];
   end

   // one cipher round; byte 0 of the block sits in the top bits
   assign rk = {rk_ff[0], rk_ff[1], rk_ff[2], rk_ff[3]};

   always_comb begin
      for (int j = 0; j < 16; j++) sb[127 - 8*j -: 8] = sbox(st_ff[127 - 8*j -: 8]);
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            sr[127 - 8*(4*c + j) -: 8] = sb[127 - 8*(4*((c + j) % 4) + j) -: 8];
         end
      end
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3;
         a0 = sr[127 - 32*c -: 8];
         a1 = sr[119 - 32*c -: 8];
         a2 = sr[111 - 32*c -: 8];
         a3 = sr[103 - 32*c -: 8];
         mc[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         mc[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         mc[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         mc[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      st_in = st_ff;
      if (cmd.ark_en) begin
         st_in = {nonce_ff, ctr_ff} ^ rk;
      end else if (cmd.rnd_en) begin
         st_in = (cmd.rnd_last ? sr : mc) ^ rk;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (cmd.out_en) begin
         rsp_ff <= {st_ff[63:0] ^ mask_lo_ff, st_ff[127:64] ^ mask_hi_ff};
      end
   end
endmodule
`default_nettype wire

// ----- rtl/aes_counter_keystream_generator_top.sv -----
// Top level of the counter-mode AES keystream generator.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser mode, tdata load_value
//  rsp     | out | rsp_tvalid/rsp_tready | tdata random_hi, random_lo
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// A generate beat runs key expansion one word a cycle (ST_EXPAND), the fetch of round
// key 0 (ST_KEYRD), the rounds on the single round unit (ST_ROUND) and the handoff
// (ST_FINISH), which waits for a free output slot. The next request is taken back in
// ST_IDLE, as rsp_tvalid rises. A load beat sets the counter from load_value and gives
// no result. Reset is synchronous and clears the CSRs, the counter and the control
// state, not the key schedule, round keys or data registers. A finished block waits in
// the output register, so the next request is taken while rsp is stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "aes_counter_keystream_generator_top_assert.svh"
module aes_counter_keystream_generator_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [63:0]  req_tdata,   // [63:0] load_value
   input  wire          req_tuser,   // [0] mode
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] random_hi, [127:64] random_lo
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [2:0]   csr_index,
   input  wire  [63:0]  csr_data
);
   import akg_pkg::*;

   akg_cmd_type    cmd;
   akg_status_type status;
   logic           req_fire;

   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   akg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_mode   (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   akg_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_fire   (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .load_value (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_data   (rsp_tdata)
   );

   `AKG_ASSERT_IMPLY(a_out_slot_free, clock, reset, cmd.out_en, !rsp_tvalid || rsp_tready)
   `AKG_ASSERT_NEXT(a_gen_blocks_intake, clock, reset, req_fire && !req_tuser, !req_tready)
   `AKG_ASSERT_NEXT(a_out_shows_valid, clock, reset, cmd.out_en, rsp_tvalid)
endmodule
`default_nettype wire
